// ===== rtl/pli_pkg.sv =====
`default_nettype none

package pli_pkg;

    // Command codes
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_ERASE  = 3'd2;
    localparam logic [2:0] CMD_POP    = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_WRITE  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 6;

    // Per-cycle operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INSERT,
        CELL_ERASE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/pli_cell.sv =====
`default_nettype none

module pli_cell #(
    parameter int PW  = 6,
    parameter int IDX = 0
) (
    input  wire logic                      clk,
    input  wire pli_pkg::cell_ctl_t        ctl,
    input  wire logic [PW-1:0]             tgt,
    input  wire logic [pli_pkg::DATA_W-1:0] left,
    input  wire logic [pli_pkg::DATA_W-1:0] right,
    output logic      [pli_pkg::DATA_W-1:0] entry,
    output logic      [pli_pkg::DATA_W-1:0] rd
);
    import pli_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              hit;
    logic              above;

    assign hit   = (tgt == MY_IDX);
    assign above = (MY_IDX > tgt);

    // Pick the new entry from the broadcast value or a neighbor
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            CELL_LOAD:
            begin
                if (hit)
                    entry_next = ctl.value;
            end
            CELL_INSERT:
            begin
                if (hit)
                    entry_next = ctl.value;
                else if (above)
                    entry_next = left;
            end
            CELL_ERASE:
            begin
                if (hit || above)
                    entry_next = right;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

    // Drive the read bus only when addressed
    assign rd = hit ? entry_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/positional_list_insert_erase_top.sv =====
`default_nettype none

// Positional list of up to DEPTH signed 32-bit entries.
// Command channel: cmd, position and value are taken at a rising edge where
// start is high and busy is low. busy never rises, so a command may be
// issued in every cycle.
// Result channel: done pulses for one cycle, in the cycle after the command
// was taken, with read_value, status and entry_count valid in that cycle.
// The receiver cannot stall; each result must be captured when done is high.
// Throughput is one command per cycle: every entry sits in its own cell,
// and the row of cells shifts all entries to their neighbors in parallel
// on the same edge that takes the command.
// A read is served from the entries as they stand before the command.
// Failed commands (bad position, full, empty) leave the list unchanged.
// Unused command codes return status ok and change nothing.
// Reset (rst_n low, asynchronous) empties the list and clears done; entry
// contents are not cleared and are only read after being written.
module positional_list_insert_erase_top #(
    parameter int DEPTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        cmd,
    input  wire logic [pli_pkg::POS_W-1:0]         position,
    input  wire logic signed [pli_pkg::DATA_W-1:0] value,
    output logic                                   done,
    output logic signed [pli_pkg::DATA_W-1:0]      read_value,
    output logic [1:0]                             status,
    output logic [pli_pkg::COUNT_W-1:0]            entry_count
);
    import pli_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   done_reg;
    logic [DATA_W-1:0]      read_value_reg;
    logic [DATA_W-1:0]      read_value_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic [COUNT_W-1:0]     entry_count_reg;

    logic                   accept;
    logic [PW-1:0]          pos_ext;
    logic [PW-1:0]          cnt_ext;
    logic                   empty;
    logic                   full;
    cell_ctl_t              ctl;
    logic [PW-1:0]          tgt;
    logic [DATA_W-1:0]      ent [DEPTH];
    logic [DATA_W-1:0]      rd_bus [DEPTH];
    logic [DATA_W-1:0]      rd_data;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(count_reg);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_COUNT);

    // Combine the addressed cell's output
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_data = rd_data | rd_bus[i];
    end

    // Decode the command into a cell operation, a new count and a status
    always_comb
    begin
        ctl.op          = CELL_HOLD;
        ctl.value       = value;
        tgt             = pos_ext;
        count_next      = count_reg;
        status_next     = ST_OK;
        read_value_next = '0;
        if (accept)
        begin
            unique case (cmd)
                CMD_INSERT:
                begin
                    if (pos_ext > cnt_ext)
                        status_next = ST_RANGE;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctl.op     = CELL_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_APPEND:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctl.op     = CELL_INSERT;
                        tgt        = cnt_ext;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_ERASE:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (pos_ext >= cnt_ext)
                        status_next = ST_RANGE;
                    else
                    begin
                        ctl.op     = CELL_ERASE;
                        count_next = count_reg - CW'(1);
                    end
                end
                CMD_POP:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                        count_next = count_reg - CW'(1);
                end
                CMD_READ:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (pos_ext >= cnt_ext)
                        status_next = ST_RANGE;
                    else
                        read_value_next = rd_data;
                end
                CMD_WRITE:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (pos_ext >= cnt_ext)
                        status_next = ST_RANGE;
                    else
                        ctl.op = CELL_LOAD;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Row of cells; each takes from its lower or upper neighbor
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = ent[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = ent[g+1];
        end

        pli_cell #(
            .PW  (PW),
            .IDX (g)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .tgt   (tgt),
            .left  (left_in),
            .right (right_in),
            .entry (ent[g]),
            .rd    (rd_bus[g])
        );
    end

    // Hold the count and the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Register the result transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg  <= read_value_next;
            status_reg      <= status_next;
            entry_count_reg <= COUNT_W'(count_next);
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire

// ===== rtl/pli_checker.sv =====
`default_nettype none

module pli_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [2:0]                        cmd,
    input wire logic                              done,
    input wire logic signed [pli_pkg::DATA_W-1:0] read_value,
    input wire logic [1:0]                        status,
    input wire logic [pli_pkg::COUNT_W-1:0]       entry_count
);
    import pli_pkg::*;

    // Every taken transaction yields a result on the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result strobe missing after accepted command");

    // No result without a command
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result strobe without accepted command");

    // Failed commands return zero data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (read_value == '0))
        else $error("nonzero read data on failed command");

    // Full only comes from insert or append
    a_full_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |->
            ($past(cmd) == CMD_INSERT || $past(cmd) == CMD_APPEND))
        else $error("full status on a command that does not add");

    // Empty status leaves an empty list
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (entry_count == '0))
        else $error("empty status with nonzero count");

endmodule

bind positional_list_insert_erase_top pli_checker u_pli_checker (.*);

`default_nettype wire

// ===== dv/tb_positional_list_insert_erase_top.sv =====
`timescale 1ns / 1ps

module tb_positional_list_insert_erase_top;
    import pli_pkg::*;

    localparam int LIST_DEPTH  = 32;
    localparam int PHASE_ITEMS = 385;
    localparam int RUN_LEN     = 48;

    // Command codes the block decodes as no-ops
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } list_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  rd;
        logic [1:0]         st;
        logic [COUNT_W-1:0] cnt;
    } list_result_t;

    typedef enum int {
        MIX_RUN,
        FILL_RUN,
        DRAIN_RUN
    } run_kind_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [2:0]               cmd = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     done;
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;

    // Shadow list state
    logic [DATA_W-1:0] list_mem [LIST_DEPTH];
    int                list_len = 0;

    list_cmd_t    pending_q[$];
    list_result_t expected_results[$];
    int           idle_pct = 0;
    int           mismatch_count = 0;

    positional_list_insert_erase_top #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .position(position),
        .value(value),
        .done(done),
        .read_value(read_value),
        .status(status),
        .entry_count(entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the shadow list and queue the result it gives
    task automatic apply_list_cmd(input logic [2:0] op, input logic [POS_W-1:0] pos,
                                  input logic [DATA_W-1:0] val);
        list_result_t res;
        int           at;
        int           i;
        res.rd = '0;
        res.st = ST_OK;
        case (op)
            CMD_INSERT, CMD_APPEND:
            begin
                at = (op == CMD_APPEND) ? list_len : int'(pos);
                // range is checked before fullness
                if (at > list_len)
                    res.st = ST_RANGE;
                else if (list_len >= LIST_DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    for (i = list_len; i > at; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[at] = val;
                    list_len++;
                end
            end
            CMD_ERASE, CMD_POP:
            begin
                at = (op == CMD_POP) ? list_len - 1 : int'(pos);
                if (list_len == 0)
                    res.st = ST_EMPTY;
                else if (at >= list_len)
                    res.st = ST_RANGE;
                else
                begin
                    for (i = at; i < list_len - 1; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            CMD_READ, CMD_WRITE:
            begin
                at = int'(pos);
                if (list_len == 0)
                    res.st = ST_EMPTY;
                else if (at >= list_len)
                    res.st = ST_RANGE;
                else if (op == CMD_READ)
                    res.rd = list_mem[at];
                else
                    list_mem[at] = val;
            end
            default:
            begin
            end
        endcase
        res.cnt = list_len[COUNT_W-1:0];
        expected_results.push_back(res);
    endtask

    task automatic queue_cmd(input logic [2:0] op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val);
        list_cmd_t c;
        c.op  = op;
        c.pos = pos;
        c.val = val;
        pending_q.push_back(c);
    endtask

    // Pick a command; the run kind steers the list toward full or empty
    function automatic list_cmd_t make_random_cmd(input run_kind_t kind);
        list_cmd_t c;
        int        roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            c.op = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
        else if (kind == FILL_RUN)
            c.op = (roll < 60) ? CMD_INSERT : (roll < 80) ? CMD_APPEND :
                   (roll < 85) ? CMD_ERASE  : (roll < 88) ? CMD_POP    :
                   (roll < 94) ? CMD_READ   : CMD_WRITE;
        else if (kind == DRAIN_RUN)
            c.op = (roll < 45) ? CMD_ERASE  : (roll < 65) ? CMD_POP    :
                   (roll < 72) ? CMD_INSERT : (roll < 76) ? CMD_APPEND :
                   (roll < 88) ? CMD_READ   : CMD_WRITE;
        else
            c.op = (roll < 23) ? CMD_INSERT : (roll < 33) ? CMD_APPEND :
                   (roll < 53) ? CMD_ERASE  : (roll < 63) ? CMD_POP    :
                   (roll < 83) ? CMD_READ   : CMD_WRITE;

        // mostly positions near the live range, some anywhere in the field
        if ($urandom_range(0, 99) < 85)
            c.pos = POS_W'($urandom_range(0, list_len));
        else
            c.pos = POS_W'($urandom_range(0, 63));

        case ($urandom_range(0, 19))
            0:       c.val = 32'h8000_0000;
            1:       c.val = 32'h7fff_ffff;
            2:       c.val = 32'h0000_0000;
            3:       c.val = 32'hffff_ffff;
            default: c.val = $urandom;
        endcase
        return c;
    endfunction

    // Driver: record accepted transactions, then present the next command
    always @(posedge clk)
    begin : drive_proc
        list_cmd_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
                apply_list_cmd(cmd, position, value);
            if (!start || !busy)
            begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    start    <= 1'b1;
                    cmd      <= nxt.op;
                    position <= nxt.pos;
                    value    <= nxt.val;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result strobe with the oldest expectation
    always @(posedge clk)
    begin : check_proc
        list_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: read_value %h status %0d entry_count %0d",
                         $time, read_value, status, entry_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_value !== want.rd)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.rd, read_value);
                    mismatch_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    mismatch_count++;
                end
                if (entry_count !== want.cnt)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.cnt, entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stim_proc
        int        phase_idle [4];
        int        ph;
        int        k;
        run_kind_t kind;
        phase_idle = '{0, 58, 0, 25};
        kind = MIX_RUN;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list: every access is flagged
        queue_cmd(CMD_ERASE, 6'd0, 32'h0);
        queue_cmd(CMD_POP, 6'd0, 32'h0);
        queue_cmd(CMD_READ, 6'd0, 32'h0);
        queue_cmd(CMD_WRITE, 6'd0, 32'h1234_5678);
        // insert past end, then at the top of the position field
        queue_cmd(CMD_INSERT, 6'd1, 32'h0);
        queue_cmd(CMD_INSERT, 6'd63, 32'hffff_ffff);
        // append, push front, insert at end and in the middle
        queue_cmd(CMD_APPEND, 6'd40, 32'h7fff_ffff);
        queue_cmd(CMD_INSERT, 6'd0, 32'h8000_0000);
        queue_cmd(CMD_INSERT, 6'd2, 32'h0);
        queue_cmd(CMD_INSERT, 6'd1, 32'hffff_ffff);
        for (k = 0; k < 5; k++)
            queue_cmd(CMD_READ, k[POS_W-1:0], 32'h0);
        queue_cmd(CMD_WRITE, 6'd2, 32'h5555_aaaa);
        queue_cmd(CMD_WRITE, 6'd63, 32'haaaa_5555);
        queue_cmd(CMD_READ, 6'd2, 32'h0);
        // unused codes change nothing
        queue_cmd(CMD_SPARE_LO, 6'd0, 32'hdead_beef);
        queue_cmd(CMD_SPARE_HI, 6'd63, 32'h8000_0000);
        // erase in the middle, pop front, bad erase, then pop twice
        queue_cmd(CMD_ERASE, 6'd1, 32'h0);
        queue_cmd(CMD_ERASE, 6'd0, 32'h0);
        queue_cmd(CMD_ERASE, 6'd5, 32'h0);
        queue_cmd(CMD_POP, 6'd0, 32'h0);
        queue_cmd(CMD_POP, 6'd0, 32'h0);

        for (ph = 0; ph < 4; ph++)
        begin
            // hold off until every outstanding result has come back
            while (pending_q.size() > 0 || start || expected_results.size() > 0)
                @(negedge clk);
            idle_pct = phase_idle[ph];
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % RUN_LEN == 0)
                    kind = run_kind_t'($urandom_range(0, 2));
                while (pending_q.size() >= 2)
                    @(negedge clk);
                pending_q.push_back(make_random_cmd(kind));
            end
        end

        // drain, then allow for the result latency
        while (pending_q.size() > 0 || start || expected_results.size() > 0)
            @(negedge clk);
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
